/* sv/dlps_pkg.sv */
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared widths, word layouts and helpers for the directional Phong shader.
// ----------------------------------------------------------------------------
`default_nettype none

package dlps_pkg;

  localparam int VEC_W     = 16;          // Q1.14 vector component
  localparam int POS_W     = 24;          // Q16.8 position component
  localparam int COL_W     = 16;          // Q1.15 color channel
  localparam int RGB_W     = 3 * COL_W;
  localparam int EXP_W     = 8;           // shininess exponent
  localparam int KL_W      = 17;          // (color * light) >> 15
  localparam int S_W       = 33;          // N . dir, Q.28
  localparam int E_W       = POS_W + 1;   // camera - hit
  localparam int SN_W      = 48;          // s * N_i
  localparam int R_W       = 22;          // reflected vector, Q.14
  localparam int Q_W       = 49;          // E . R
  localparam int NRM_W     = 50;          // squared lengths
  localparam int ROOT_W    = NRM_W / 2;
  localparam int DEN_W     = 2 * ROOT_W;
  localparam int DIV_STEPS = 15;
  localparam int MAX_EXP   = (1 << EXP_W) - 1;
  localparam int CLAMP_W   = 21;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int IN_W      = 224;
  localparam int OUT_W     = 6 * COL_W;

  localparam logic [COL_W-1:0] ONE = COL_W'(32768);

  typedef enum logic [2:0] {
    REG_DIR_X = 3'd0,
    REG_DIR_Y = 3'd1,
    REG_DIR_Z = 3'd2,
    REG_LIGHT = 3'd3,
    REG_CAM_X = 3'd4,
    REG_CAM_Y = 3'd5,
    REG_CAM_Z = 3'd6
  } dlps_reg_e;

  typedef struct packed {
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] dir_z;
    logic        [RGB_W-1:0] light_rgb;
    logic signed [POS_W-1:0] cam_x;
    logic signed [POS_W-1:0] cam_y;
    logic signed [POS_W-1:0] cam_z;
  } dlps_cfg_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] normal_x;
    logic signed [VEC_W-1:0] normal_y;
    logic signed [VEC_W-1:0] normal_z;
    logic signed [POS_W-1:0] hit_x;
    logic signed [POS_W-1:0] hit_y;
    logic signed [POS_W-1:0] hit_z;
    logic        [RGB_W-1:0] diffuse_rgb;
    logic        [RGB_W-1:0] specular_rgb;
    logic        [EXP_W-1:0] shininess;
  } dlps_item_t;

  typedef struct packed {
    logic                  spec_zero;
    logic [RGB_W-1:0]      diff;
    logic [3*KL_W-1:0]     ksl;
  } dlps_pow_side_t;

  typedef struct packed {
    dlps_pow_side_t        pw;
    logic [EXP_W-1:0]      shin;
  } dlps_div_side_t;

  typedef struct packed {
    dlps_div_side_t        dv;
    logic signed [Q_W-1:0] q;
  } dlps_sq_side_t;

  function automatic logic [COL_W-1:0] clamp_one(input logic [CLAMP_W-1:0] v);
    logic [COL_W-1:0] r;
    r = (v > CLAMP_W'(ONE)) ? ONE : v[COL_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/dlps_geom.sv */
// ----------------------------------------------------------------------------
// dlps_geom
// Six-stage front end: dot products, diffuse terms, reflection, view vector.
// ----------------------------------------------------------------------------
`default_nettype none

module dlps_geom (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire dlps_pkg::dlps_item_t      item_i,
  input  wire dlps_pkg::dlps_cfg_t       cfg_i,
  output logic                           valid_o,
  output logic [dlps_pkg::NRM_W-1:0]     ee_o,
  output logic [dlps_pkg::NRM_W-1:0]     rr_o,
  output dlps_pkg::dlps_sq_side_t        side_o
);
  import dlps_pkg::*;

  localparam int ND_W = 2 * VEC_W;
  localparam int DP_W = KL_W + 32;
  localparam int EE_W = 2 * E_W - 2;
  localparam int ER_W = E_W + R_W;
  localparam int RR_W = 2 * R_W - 1;

  logic signed [VEC_W-1:0] dir [3];
  logic signed [VEC_W-1:0] nrm [3];
  logic signed [POS_W-1:0] cam [3];
  logic signed [POS_W-1:0] hit [3];

  assign dir[0] = cfg_i.dir_x;
  assign dir[1] = cfg_i.dir_y;
  assign dir[2] = cfg_i.dir_z;
  assign cam[0] = cfg_i.cam_x;
  assign cam[1] = cfg_i.cam_y;
  assign cam[2] = cfg_i.cam_z;
  assign nrm[0] = item_i.normal_x;
  assign nrm[1] = item_i.normal_y;
  assign nrm[2] = item_i.normal_z;
  assign hit[0] = item_i.hit_x;
  assign hit[1] = item_i.hit_y;
  assign hit[2] = item_i.hit_z;

  logic [5:0] v_q;

  // stage 1
  logic signed [VEC_W-1:0] n1_q  [3];
  logic signed [ND_W-1:0]  nd1_q [3];
  logic signed [E_W-1:0]   e1_q  [3];
  logic        [31:0]      kd1_q [3];
  logic        [31:0]      ks1_q [3];
  logic        [EXP_W-1:0] shin1_q;
  // stage 2
  logic signed [S_W-1:0]   s2_q;
  logic signed [VEC_W-1:0] n2_q  [3];
  logic signed [E_W-1:0]   e2_q  [3];
  logic        [KL_W-1:0]  kl2_q [3];
  logic        [3*KL_W-1:0] ksl2_q;
  logic        [EXP_W-1:0] shin2_q;
  // stage 3
  logic                    tpos3_q, sz3_q;
  logic        [DP_W-1:0]  dp3_q [3];
  logic signed [SN_W-1:0]  sn3_q [3];
  logic        [EE_W-1:0]  ee3_q [3];
  logic signed [E_W-1:0]   e3_q  [3];
  logic        [3*KL_W-1:0] ksl3_q;
  logic        [EXP_W-1:0] shin3_q;
  // stage 4
  logic                    sz4_q;
  logic        [RGB_W-1:0] diff4_q;
  logic signed [R_W-1:0]   r4_q  [3];
  logic        [NRM_W-1:0] ee4_q;
  logic signed [E_W-1:0]   e4_q  [3];
  logic        [3*KL_W-1:0] ksl4_q;
  logic        [EXP_W-1:0] shin4_q;
  // stage 5
  logic                    sz5_q;
  logic        [RGB_W-1:0] diff5_q;
  logic signed [ER_W-1:0]  er5_q [3];
  logic        [RR_W-1:0]  rr5_q [3];
  logic        [NRM_W-1:0] ee5_q;
  logic        [3*KL_W-1:0] ksl5_q;
  logic        [EXP_W-1:0] shin5_q;
  // stage 6
  logic                    sz6_q;
  logic        [RGB_W-1:0] diff6_q;
  logic signed [Q_W-1:0]   q6_q;
  logic        [NRM_W-1:0] rr6_q;
  logic        [NRM_W-1:0] ee6_q;
  logic        [3*KL_W-1:0] ksl6_q;
  logic        [EXP_W-1:0] shin6_q;

  logic signed [S_W-1:0]    t3;
  logic signed [2*E_W-1:0]  esq3 [3];
  logic signed [SN_W-1:0]   nsn4 [3];
  logic signed [SN_W-1:0]   sh4  [3];
  logic signed [R_W-1:0]    rp4  [3];
  logic signed [2*R_W-1:0]  rsq5 [3];

  always_comb begin
    t3 = -s2_q;
    for (int i = 0; i < 3; i++) begin
      esq3[i] = e2_q[i] * e2_q[i];
      nsn4[i] = -sn3_q[i];
      sh4[i]  = nsn4[i] >>> 27;
      rp4[i]  = sh4[i][R_W-1:0];
      rsq5[i] = r4_q[i] * r4_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        n1_q[i]  <= nrm[i];
        nd1_q[i] <= nrm[i] * dir[i];
        e1_q[i]  <= cam[i] - hit[i];
        kd1_q[i] <= item_i.diffuse_rgb[COL_W*i +: COL_W] * cfg_i.light_rgb[COL_W*i +: COL_W];
        ks1_q[i] <= item_i.specular_rgb[COL_W*i +: COL_W] * cfg_i.light_rgb[COL_W*i +: COL_W];
      end
      shin1_q <= item_i.shininess;

      s2_q <= nd1_q[0] + nd1_q[1] + nd1_q[2];
      for (int i = 0; i < 3; i++) begin
        n2_q[i]  <= n1_q[i];
        e2_q[i]  <= e1_q[i];
        kl2_q[i] <= kd1_q[i][31:15];
        ksl2_q[KL_W*i +: KL_W] <= ks1_q[i][31:15];
      end
      shin2_q <= shin1_q;

      tpos3_q <= t3 > 0;
      sz3_q   <= s2_q > 0;
      for (int i = 0; i < 3; i++) begin
        dp3_q[i] <= kl2_q[i] * t3[31:0];
        sn3_q[i] <= s2_q * n2_q[i];
        ee3_q[i] <= esq3[i][EE_W-1:0];
        e3_q[i]  <= e2_q[i];
      end
      ksl3_q  <= ksl2_q;
      shin3_q <= shin2_q;

      sz4_q <= sz3_q;
      for (int i = 0; i < 3; i++) begin
        diff4_q[COL_W*i +: COL_W] <= tpos3_q ? clamp_one(dp3_q[i][DP_W-1:28]) : '0;
        r4_q[i] <= dir[i] + rp4[i];
        e4_q[i] <= e3_q[i];
      end
      ee4_q   <= NRM_W'(ee3_q[0]) + NRM_W'(ee3_q[1]) + NRM_W'(ee3_q[2]);
      ksl4_q  <= ksl3_q;
      shin4_q <= shin3_q;

      sz5_q   <= sz4_q;
      diff5_q <= diff4_q;
      for (int i = 0; i < 3; i++) begin
        er5_q[i] <= e4_q[i] * r4_q[i];
        rr5_q[i] <= rsq5[i][RR_W-1:0];
      end
      ee5_q   <= ee4_q;
      ksl5_q  <= ksl4_q;
      shin5_q <= shin4_q;

      sz6_q   <= sz5_q;
      diff6_q <= diff5_q;
      q6_q    <= er5_q[0] + er5_q[1] + er5_q[2];
      rr6_q   <= NRM_W'(rr5_q[0]) + NRM_W'(rr5_q[1]) + NRM_W'(rr5_q[2]);
      ee6_q   <= ee5_q;
      ksl6_q  <= ksl5_q;
      shin6_q <= shin5_q;
    end
  end

  assign valid_o                 = v_q[5];
  assign ee_o                    = ee6_q;
  assign rr_o                    = rr6_q;
  assign side_o.q                = q6_q;
  assign side_o.dv.shin          = shin6_q;
  assign side_o.dv.pw.spec_zero  = sz6_q;
  assign side_o.dv.pw.diff       = diff6_q;
  assign side_o.dv.pw.ksl        = ksl6_q;

endmodule

`default_nettype wire

/* sv/dlps_sqrt.sv */
// ----------------------------------------------------------------------------
// dlps_sqrt
// Two floor square roots side by side, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dlps_sqrt #(
  parameter int W = dlps_pkg::NRM_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [W-1:0]          a_i,
  input  wire logic [W-1:0]          b_i,
  input  wire dlps_pkg::dlps_sq_side_t side_i,
  output logic                       valid_o,
  output logic [W/2-1:0]             ra_o,
  output logic [W/2-1:0]             rb_o,
  output dlps_pkg::dlps_sq_side_t    side_o
);
  import dlps_pkg::*;

  localparam int N = W / 2;

  logic [N-1:0]   v_q;
  logic [W-1:0]   x_q    [N][2];
  logic [W:0]     r_q    [N][2];
  dlps_sq_side_t  side_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stg
    localparam logic [W:0] BIT = (W+1)'(1) << (2 * (N - 1 - k));
    logic [W-1:0]  xin [2];
    logic [W:0]    rin [2];
    logic [W:0]    sum [2];
    dlps_sq_side_t sin;

    if (k == 0) begin : g_first
      assign xin[0] = a_i;
      assign xin[1] = b_i;
      assign rin[0] = '0;
      assign rin[1] = '0;
      assign sin    = side_i;
    end else begin : g_next
      assign xin[0] = x_q[k-1][0];
      assign xin[1] = x_q[k-1][1];
      assign rin[0] = r_q[k-1][0];
      assign rin[1] = r_q[k-1][1];
      assign sin    = side_q[k-1];
    end

    assign sum[0] = rin[0] + BIT;
    assign sum[1] = rin[1] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int j = 0; j < 2; j++) begin
          if ({1'b0, xin[j]} >= sum[j]) begin
            x_q[k][j] <= xin[j] - sum[j][W-1:0];
            r_q[k][j] <= (rin[j] >> 1) + BIT;
          end else begin
            x_q[k][j] <= xin[j];
            r_q[k][j] <= rin[j] >> 1;
          end
        end
        side_q[k] <= sin;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign ra_o    = r_q[N-1][0][N-1:0];
  assign rb_o    = r_q[N-1][1][N-1:0];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire

/* sv/dlps_div.sv */
// ----------------------------------------------------------------------------
// dlps_div
// Cosine of view and reflection: length product, then restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module dlps_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [dlps_pkg::ROOT_W-1:0]  le_i,
  input  wire logic [dlps_pkg::ROOT_W-1:0]  lr_i,
  input  wire logic signed [dlps_pkg::Q_W-1:0] q_i,
  input  wire dlps_pkg::dlps_div_side_t     side_i,
  output logic                              valid_o,
  output logic [dlps_pkg::COL_W-1:0]        cos_o,
  output dlps_pkg::dlps_div_side_t          side_o
);
  import dlps_pkg::*;

  localparam int REM_W = DEN_W + 1;
  localparam int NS    = DIV_STEPS + 2;

  logic [NS-1:0]         v_q;
  logic [DEN_W-1:0]      den0_q;
  logic signed [Q_W-1:0] q0_q;
  dlps_div_side_t        side_q [NS];
  logic                  zero_q [DIV_STEPS+1];
  logic                  sat_q  [DIV_STEPS+1];
  logic [DEN_W-1:0]      den_q  [DIV_STEPS+1];
  logic [REM_W-1:0]      rem_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]  quo_q  [DIV_STEPS+1];

  logic [Q_W-2:0] qmag;
  assign qmag = q0_q[Q_W-2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den0_q    <= le_i * lr_i;
      q0_q      <= q_i;
      side_q[0] <= side_i;

      zero_q[0] <= (q0_q <= 0) || (den0_q == '0);
      sat_q[0]  <= DEN_W'(qmag) >= den0_q;
      den_q[0]  <= den0_q;
      rem_q[0]  <= REM_W'(qmag);
      quo_q[0]  <= '0;
      side_q[1] <= side_q[0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [REM_W-1:0] sh;
    logic             ge;
    assign sh = {rem_q[k][REM_W-2:0], 1'b0};
    assign ge = sh >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? sh - {1'b0, den_q[k]} : sh;
        quo_q[k+1]  <= {quo_q[k][DIV_STEPS-2:0], ge};
        den_q[k+1]  <= den_q[k];
        zero_q[k+1] <= zero_q[k];
        sat_q[k+1]  <= sat_q[k];
        side_q[k+2] <= side_q[k+1];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign cos_o   = zero_q[DIV_STEPS] ? '0 :
                   sat_q[DIV_STEPS]  ? ONE : {1'b0, quo_q[DIV_STEPS]};

endmodule

`default_nettype wire

/* sv/dlps_pow.sv */
// ----------------------------------------------------------------------------
// dlps_pow
// Truncating power chain: one multiply per stage, applied while stage < n.
// ----------------------------------------------------------------------------
`default_nettype none

module dlps_pow (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [dlps_pkg::COL_W-1:0] cos_i,
  input  wire dlps_pkg::dlps_div_side_t   side_i,
  output logic                            valid_o,
  output logic [dlps_pkg::COL_W-1:0]      p_o,
  output dlps_pkg::dlps_pow_side_t        side_o
);
  import dlps_pkg::*;

  logic [MAX_EXP-1:0] v_q;
  logic [COL_W-1:0]   p_q    [MAX_EXP];
  logic [COL_W-1:0]   c_q    [MAX_EXP];
  logic [EXP_W-1:0]   n_q    [MAX_EXP];
  dlps_pow_side_t     side_q [MAX_EXP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[MAX_EXP-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < MAX_EXP; k++) begin : g_stg
    logic [COL_W-1:0]   pin, cin;
    logic [EXP_W-1:0]   nin;
    dlps_pow_side_t     sin;
    logic [2*COL_W-1:0] prod;

    if (k == 0) begin : g_first
      assign pin = ONE;
      assign cin = cos_i;
      assign nin = side_i.shin;
      assign sin = side_i.pw;
    end else begin : g_next
      assign pin = p_q[k-1];
      assign cin = c_q[k-1];
      assign nin = n_q[k-1];
      assign sin = side_q[k-1];
    end

    assign prod = pin * cin;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k]    <= (EXP_W'(k) < nin) ? prod[COL_W+14:15] : pin;
        c_q[k]    <= cin;
        n_q[k]    <= nin;
        side_q[k] <= sin;
      end
    end
  end

  assign valid_o = v_q[MAX_EXP-1];
  assign p_o     = p_q[MAX_EXP-1];
  assign side_o  = side_q[MAX_EXP-1];

endmodule

`default_nettype wire

/* sv/directional_light_phong_shade_top.sv */
// ----------------------------------------------------------------------------
// directional_light_phong_shade_top
// Phong diffuse and specular terms of one directional light per shading point.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the result word is not held;
// the full pipeline advances on one enable.
// Most of the depth comes from the 255-stage shininess power chain (one multiply each).
// Reset: asynchronous, active low; clears all valid bits and loads the
// register defaults (light pointing down -z, black light, camera at origin).
// ----------------------------------------------------------------------------
`default_nettype none

module directional_light_phong_shade_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] normal_x, [31:16] normal_y, [47:32] normal_z, [71:48] hit_x,
  // [95:72] hit_y, [119:96] hit_z, [167:120] diffuse_rgb,
  // [215:168] specular_rgb, [223:216] shininess
  input  wire logic [dlps_pkg::IN_W-1:0]     s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [15:0] diff_r, [31:16] diff_g, [47:32] diff_b,
  // [63:48] spec_r, [79:64] spec_g, [95:80] spec_b
  output logic [dlps_pkg::OUT_W-1:0]         m_axis_tdata,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dlps_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [dlps_pkg::DATA_W-1:0]   pwdata,
  output logic [dlps_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import dlps_pkg::*;

  // --------------------------------------------------------------------------
  // Register file: 64-bit slots at byte address 8*index.
  // --------------------------------------------------------------------------
  dlps_cfg_t cfg_q;
  dlps_reg_e reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = dlps_reg_e'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_x     <= '0;
      cfg_q.dir_y     <= '0;
      cfg_q.dir_z     <= -VEC_W'(16384);
      cfg_q.light_rgb <= '0;
      cfg_q.cam_x     <= '0;
      cfg_q.cam_y     <= '0;
      cfg_q.cam_z     <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DIR_X: cfg_q.dir_x     <= pwdata[VEC_W-1:0];
        REG_DIR_Y: cfg_q.dir_y     <= pwdata[VEC_W-1:0];
        REG_DIR_Z: cfg_q.dir_z     <= pwdata[VEC_W-1:0];
        REG_LIGHT: cfg_q.light_rgb <= pwdata[RGB_W-1:0];
        REG_CAM_X: cfg_q.cam_x     <= pwdata[POS_W-1:0];
        REG_CAM_Y: cfg_q.cam_y     <= pwdata[POS_W-1:0];
        REG_CAM_Z: cfg_q.cam_z     <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back sign-extended like the write side interprets the data; the light color is zero-extended.
  always_comb begin
    case (reg_sel)
      REG_DIR_X: prdata = DATA_W'(cfg_q.dir_x);
      REG_DIR_Y: prdata = DATA_W'(cfg_q.dir_y);
      REG_DIR_Z: prdata = DATA_W'(cfg_q.dir_z);
      REG_LIGHT: prdata = DATA_W'(cfg_q.light_rgb);
      REG_CAM_X: prdata = DATA_W'(cfg_q.cam_x);
      REG_CAM_Y: prdata = DATA_W'(cfg_q.cam_y);
      REG_CAM_Z: prdata = DATA_W'(cfg_q.cam_z);
      default:   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: advance everything unless the output word is held.
  // Bubbles travel with cleared valid bits, so nothing is lost or repeated.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic en;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  dlps_item_t item;
  assign item.normal_x     = s_axis_tdata[15:0];
  assign item.normal_y     = s_axis_tdata[31:16];
  assign item.normal_z     = s_axis_tdata[47:32];
  assign item.hit_x        = s_axis_tdata[71:48];
  assign item.hit_y        = s_axis_tdata[95:72];
  assign item.hit_z        = s_axis_tdata[119:96];
  assign item.diffuse_rgb  = s_axis_tdata[167:120];
  assign item.specular_rgb = s_axis_tdata[215:168];
  assign item.shininess    = s_axis_tdata[223:216];

  // Geometry: dot products, diffuse, reflection, squared lengths (6 stages).
  logic             g_valid;
  logic [NRM_W-1:0] g_ee, g_rr;
  dlps_sq_side_t    g_side;

  dlps_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (item),
    .cfg_i   (cfg_q),
    .valid_o (g_valid),
    .ee_o    (g_ee),
    .rr_o    (g_rr),
    .side_o  (g_side)
  );

  // Lengths of view and reflection vectors (25 stages).
  logic              r_valid;
  logic [ROOT_W-1:0] r_le, r_lr;
  dlps_sq_side_t     r_side;

  dlps_sqrt #(
    .W (NRM_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_valid),
    .a_i     (g_ee),
    .b_i     (g_rr),
    .side_i  (g_side),
    .valid_o (r_valid),
    .ra_o    (r_le),
    .rb_o    (r_lr),
    .side_o  (r_side)
  );

  // Cosine, saturated to one and zero for a back-facing view (17 stages).
  logic             d_valid;
  logic [COL_W-1:0] d_cos;
  dlps_div_side_t   d_side;

  dlps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_valid),
    .le_i    (r_le),
    .lr_i    (r_lr),
    .q_i     (r_side.q),
    .side_i  (r_side.dv),
    .valid_o (d_valid),
    .cos_o   (d_cos),
    .side_o  (d_side)
  );

  // cos^n with truncation after every multiply (255 stages).
  logic             p_valid;
  logic [COL_W-1:0] p_pow;
  dlps_pow_side_t   p_side;

  dlps_pow u_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .cos_i   (d_cos),
    .side_i  (d_side),
    .valid_o (p_valid),
    .p_o     (p_pow),
    .side_o  (p_side)
  );

  // --------------------------------------------------------------------------
  // Specular scale, then clamp into the output register.
  // --------------------------------------------------------------------------
  logic                  f_valid_q;
  logic                  f_zero_q;
  logic [RGB_W-1:0]      f_diff_q;
  logic [KL_W+COL_W-1:0] f_prod_q [3];
  logic [OUT_W-1:0]      out_data_q;
  logic [RGB_W-1:0]      spec;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      spec[COL_W*c +: COL_W] = f_zero_q ? '0 :
        clamp_one(CLAMP_W'(f_prod_q[c][KL_W+COL_W-1:15]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q   <= p_valid;
      out_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_zero_q <= p_side.spec_zero;
      f_diff_q <= p_side.diff;
      for (int c = 0; c < 3; c++) begin
        f_prod_q[c] <= p_side.ksl[KL_W*c +: KL_W] * p_pow;
      end
      out_data_q <= {spec, f_diff_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* sv/dlps_check.sv */
// ----------------------------------------------------------------------------
// dlps_check
// Port-level checks for the shader, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dlps_check (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,
  input wire logic        pready
);

  // Hold a stalled result word.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Every channel is clamped to one.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= 16'd32768) &&
      (m_axis_tdata[31:16] <= 16'd32768) && (m_axis_tdata[47:32] <= 16'd32768) &&
      (m_axis_tdata[63:48] <= 16'd32768) && (m_axis_tdata[79:64] <= 16'd32768) &&
      (m_axis_tdata[95:80] <= 16'd32768))
    else $error("channel above one");

  // An empty output register never stalls the input side.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A result word that is being taken never stalls the input side.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("register port not ready");

endmodule

bind directional_light_phong_shade_top dlps_check u_dlps_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

`default_nettype wire
